// ===== sv/gyro_pickup_detector_assert.svh =====
// assertion macros for the gyro pickup detector
`ifndef GYRO_PICKUP_DETECTOR_ASSERT_SVH
`define GYRO_PICKUP_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define GPD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define GPD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GPD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define GPD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/gpd_pkg.sv =====
package gpd_pkg;

    localparam int GYRO_W    = 16;
    localparam int SUM_W     = 24;
    localparam int MEAN_W    = 20;
    localparam int THR_W     = 20;
    localparam int LIMIT_W   = 8;
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int ENTRY_W   = AXES * MEAN_W;
    localparam int FRAC_BITS = 4;
    localparam int DIV_W     = SUM_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;
    localparam int APB_W      = 32;
    localparam int PADDR_W    = 3;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(210);
    localparam logic [LIMIT_W-1:0] WINDOW_RESET    = LIMIT_W'(12);

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_EVAL   = 1'b1
    } op_t;

    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_WINDOW    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_GYRO     = 2'd1,
        MODE_ACTIVE   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EVT_NONE      = 2'd0,
        EVT_PICKED_UP = 2'd1,
        EVT_PUT_DOWN  = 2'd2
    } pick_event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DSTART,
        ST_DWAIT,
        ST_POST,
        ST_SCAN,
        ST_SPREAD,
        ST_FINISH
    } seq_state_t;

endpackage

// ===== sv/gpd_divider.sv =====
// restoring divider, one quotient bit per cycle
module gpd_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [gpd_pkg::DIV_W-1:0]        dividend,
    input  logic [gpd_pkg::LIMIT_W-1:0]      divisor,
    output logic [gpd_pkg::DIV_W-1:0]        quotient,
    output logic                             done
);

    localparam logic [gpd_pkg::DIV_CNT_W-1:0] LAST = gpd_pkg::DIV_CNT_W'(gpd_pkg::DIV_W - 1);

    logic                            busy_reg;
    logic                            done_reg;
    logic [gpd_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [gpd_pkg::LIMIT_W-1:0]     den_reg;
    logic [gpd_pkg::LIMIT_W-1:0]     rem_reg;
    logic [gpd_pkg::DIV_W-1:0]       quo_reg;

    logic [gpd_pkg::LIMIT_W:0]       trial;
    logic                            ge;
    logic [gpd_pkg::LIMIT_W:0]       diff;

    assign trial = {rem_reg, quo_reg[gpd_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[gpd_pkg::LIMIT_W-1:0] : trial[gpd_pkg::LIMIT_W-1:0];
            quo_reg <= {quo_reg[gpd_pkg::DIV_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== sv/gpd_history.sv =====
// mean history, one entry of three axis means per slot
module gpd_history #(
    parameter int DEPTH  = 3,
    parameter int IDX_W  = 2
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [IDX_W-1:0]                wr_idx,
    input  logic [gpd_pkg::ENTRY_W-1:0]     wr_data,
    input  logic [IDX_W-1:0]                rd_idx,
    output logic [gpd_pkg::ENTRY_W-1:0]     rd_data
);

    logic [gpd_pkg::ENTRY_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_idx];

endmodule

// ===== sv/gyro_pickup_detector.sv =====
// channel   dir   handshake                 payload
// s_        in    s_tvalid / s_tready       s_tuser op, s_tdata flags and gyro x y z
// m_        out   m_tvalid / m_tready       m_tdata level, event, mode, irq, fifo
// apb       in    psel / penable / pready   paddr, pwdata write, prdata read
//
// a sample transfer is taken while the sequencer is idle and never stalls the input
// an evaluate transfer goes from EVAL straight to FINISH when no mean is needed;
//   when a window is taken, the shared divider works on each axis in turn, and
//   once the history is full, its entries are scanned for each axis in turn
// s_tready is low while an evaluate transfer is being worked on
// a finished result waits in the output register; a stalled m_ side holds
//   only the final step of the next evaluate transfer
// aresetn is synchronous, active low; the history needs no clearing pass

`include "gyro_pickup_detector_assert.svh"

module gyro_pickup_detector #(
    parameter int HISTORY_DEPTH = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // asleep[0], window_ready[1], gyro_x[17:2], gyro_y[33:18], gyro_z[49:34]
    input  logic [gpd_pkg::IN_DATA_W-1:0]       s_tdata,
    // op[0]
    input  logic                                s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // picked_up[0], pick_event[2:1], mode[4:3], sleep_detect_on[5],
    // fifo_running[6]
    output logic [gpd_pkg::OUT_DATA_W-1:0]      m_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gpd_pkg::PADDR_W-1:0]         paddr,
    input  logic [gpd_pkg::APB_W-1:0]           pwdata,
    output logic [gpd_pkg::APB_W-1:0]           prdata,
    output logic                                pready
);

    localparam int HIDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SLOT_W = FILL_W + 1;
    localparam logic [HIDX_W-1:0] LAST_ENT = HIDX_W'(HISTORY_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] DEPTH_S  = SLOT_W'(HISTORY_DEPTH);
    localparam logic [gpd_pkg::AXIS_W-1:0] LAST_AXIS = gpd_pkg::AXIS_W'(gpd_pkg::AXES - 1);

    // sequencer and block state
    gpd_pkg::seq_state_t state_reg, state_next;
    gpd_pkg::mode_t      mode_reg, mode_next;

    logic signed [gpd_pkg::SUM_W-1:0]   sum_reg [gpd_pkg::AXES];
    logic [gpd_pkg::LIMIT_W-1:0]        count_reg;
    logic [FILL_W-1:0]                  fill_reg, fill_next;
    logic [HIDX_W-1:0]                  head_reg, head_next;
    logic                               level_reg, level_next;
    logic                               irq_reg, irq_next;
    logic                               fifo_reg, fifo_next;
    logic [gpd_pkg::THR_W-1:0]          thr_reg;
    logic [gpd_pkg::LIMIT_W-1:0]        limit_reg;

    // per-item working registers
    logic                               asleep_reg;
    logic                               ready_reg;
    logic [gpd_pkg::AXIS_W-1:0]         axis_reg;
    logic [HIDX_W-1:0]                  ent_reg;
    logic signed [gpd_pkg::MEAN_W-1:0]  lo_reg, hi_reg;
    logic signed [gpd_pkg::MEAN_W-1:0]  mean_reg [gpd_pkg::AXES];
    logic                               neg_reg;
    logic                               twitch_reg;

    logic                               m_tvalid_reg;
    logic [gpd_pkg::OUT_DATA_W-1:0]     m_tdata_reg;

    // sequencer strobes
    logic in_ready;
    logic div_start;
    logic scan_step;
    logic fin_fire;
    logic out_free;

    logic in_fire;
    logic acc_fire;
    logic need_mean;
    logic hist_full;
    logic over;
    logic clear_win;
    logic restart;
    logic push;
    logic [HIDX_W-1:0] push_slot;
    gpd_pkg::pick_event_t evt;

    logic signed [gpd_pkg::DIV_W-1:0]   scaled;
    logic [gpd_pkg::DIV_W-1:0]          magnitude;
    logic [gpd_pkg::DIV_W-1:0]          quotient;
    logic                               div_done;
    logic [gpd_pkg::MEAN_W-1:0]         q_low;
    logic signed [gpd_pkg::MEAN_W-1:0]  mean_val;
    logic signed [gpd_pkg::MEAN_W-1:0]  hist_val;
    logic signed [gpd_pkg::MEAN_W:0]    spread;
    logic [gpd_pkg::ENTRY_W-1:0]        hist_rd;
    logic [SLOT_W-1:0]                  slot_sum;
    logic signed [gpd_pkg::GYRO_W-1:0]  gyro_in [gpd_pkg::AXES];

    logic cfg_wr;

    assign in_fire  = s_tvalid && in_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    // input fields
    assign gyro_in[0] = s_tdata[17:2];
    assign gyro_in[1] = s_tdata[33:18];
    assign gyro_in[2] = s_tdata[49:34];

    assign acc_fire = in_fire && (s_tuser == gpd_pkg::OP_SAMPLE) && fifo_reg &&
                      (count_reg < limit_reg);

    assign need_mean = ready_reg &&
                       ((mode_reg == gpd_pkg::MODE_GYRO) ||
                        ((mode_reg == gpd_pkg::MODE_ACTIVE) && !asleep_reg));
    assign hist_full = fill_reg >= FULL_CNT;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gpd_pkg::ST_IDLE: begin
                if (in_fire && (s_tuser == gpd_pkg::OP_EVAL)) begin
                    state_next = gpd_pkg::ST_EVAL;
                end
            end
            gpd_pkg::ST_EVAL: begin
                state_next = need_mean ? gpd_pkg::ST_DSTART : gpd_pkg::ST_FINISH;
            end
            gpd_pkg::ST_DSTART: begin
                state_next = gpd_pkg::ST_DWAIT;
            end
            gpd_pkg::ST_DWAIT: begin
                if (div_done) begin
                    state_next = (axis_reg == LAST_AXIS) ? gpd_pkg::ST_POST
                                                         : gpd_pkg::ST_DSTART;
                end
            end
            gpd_pkg::ST_POST: begin
                state_next = hist_full ? gpd_pkg::ST_SCAN : gpd_pkg::ST_FINISH;
            end
            gpd_pkg::ST_SCAN: begin
                if (ent_reg == LAST_ENT) begin
                    state_next = gpd_pkg::ST_SPREAD;
                end
            end
            gpd_pkg::ST_SPREAD: begin
                if (over || (axis_reg == LAST_AXIS)) begin
                    state_next = gpd_pkg::ST_FINISH;
                end else begin
                    state_next = gpd_pkg::ST_SCAN;
                end
            end
            gpd_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = gpd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gpd_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        scan_step = 1'b0;
        fin_fire  = 1'b0;
        case (state_reg)
            gpd_pkg::ST_IDLE:   in_ready  = 1'b1;
            gpd_pkg::ST_DSTART: div_start = 1'b1;
            gpd_pkg::ST_SCAN:   scan_step = 1'b1;
            gpd_pkg::ST_FINISH: fin_fire  = out_free;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gpd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // shared divider: |sum * 16| / count, one axis at a time
    assign scaled    = {sum_reg[axis_reg], {gpd_pkg::FRAC_BITS{1'b0}}};
    assign magnitude = scaled[gpd_pkg::DIV_W-1] ? gpd_pkg::DIV_W'(-scaled)
                                                : gpd_pkg::DIV_W'(scaled);

    gpd_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (magnitude),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // quotient magnitude stays within 2^19, so the low bits carry the mean
    assign q_low    = quotient[gpd_pkg::MEAN_W-1:0];
    assign mean_val = (count_reg == '0) ? '0 :
                      neg_reg ? $signed(-q_low) : $signed(q_low);

    // history storage
    assign slot_sum  = SLOT_W'(head_reg) + SLOT_W'(fill_reg);
    assign push_slot = (slot_sum >= DEPTH_S) ? HIDX_W'(slot_sum - DEPTH_S)
                                             : HIDX_W'(slot_sum);

    gpd_history #(
        .DEPTH (HISTORY_DEPTH),
        .IDX_W (HIDX_W)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (fin_fire && push),
        .wr_idx  (hist_full ? head_reg : push_slot),
        .wr_data ({mean_reg[2], mean_reg[1], mean_reg[0]}),
        .rd_idx  (ent_reg),
        .rd_data (hist_rd)
    );

    // shared compare: running min and max, then spread against threshold
    assign hist_val = $signed(hist_rd[axis_reg*gpd_pkg::MEAN_W +: gpd_pkg::MEAN_W]);
    assign spread   = {hi_reg[gpd_pkg::MEAN_W-1], hi_reg} -
                      {lo_reg[gpd_pkg::MEAN_W-1], lo_reg};
    assign over     = spread > $signed({1'b0, thr_reg});

    // mode step, applied when the result is loaded
    always_comb begin
        mode_next  = mode_reg;
        level_next = level_reg;
        irq_next   = irq_reg;
        fifo_next  = fifo_reg;
        clear_win  = 1'b0;
        restart    = 1'b0;
        push       = 1'b0;
        case (mode_reg)
            gpd_pkg::MODE_GYRO: begin
                if (ready_reg) begin
                    clear_win = 1'b1;
                    push      = 1'b1;
                    if (hist_full) begin
                        if (twitch_reg) begin
                            level_next = 1'b1;
                        end else begin
                            mode_next = gpd_pkg::MODE_ACTIVE;
                            irq_next  = 1'b1;
                        end
                    end
                end
            end
            gpd_pkg::MODE_ACTIVE: begin
                if (asleep_reg) begin
                    level_next = 1'b0;
                    mode_next  = gpd_pkg::MODE_INACTIVE;
                    fifo_next  = 1'b0;
                end else if (ready_reg) begin
                    clear_win = 1'b1;
                    push      = 1'b1;
                    if (hist_full && twitch_reg) begin
                        level_next = 1'b1;
                        mode_next  = gpd_pkg::MODE_GYRO;
                        irq_next   = 1'b0;
                    end
                end
            end
            default: begin
                // inactive, and the unused code acts the same
                if (!asleep_reg) begin
                    mode_next = gpd_pkg::MODE_GYRO;
                    irq_next  = 1'b0;
                    fifo_next = 1'b1;
                    clear_win = 1'b1;
                    restart   = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        head_next = head_reg;
        if (restart) begin
            fill_next = '0;
            head_next = '0;
        end else if (push) begin
            if (hist_full) begin
                head_next = (head_reg == LAST_ENT) ? '0 : head_reg + 1'b1;
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb begin
        if (level_next == level_reg) begin
            evt = gpd_pkg::EVT_NONE;
        end else if (level_next) begin
            evt = gpd_pkg::EVT_PICKED_UP;
        end else begin
            evt = gpd_pkg::EVT_PUT_DOWN;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= gpd_pkg::MODE_ACTIVE;
            count_reg    <= '0;
            fill_reg     <= '0;
            head_reg     <= '0;
            level_reg    <= 1'b0;
            irq_reg      <= 1'b1;
            fifo_reg     <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (acc_fire) begin
                count_reg <= count_reg + 1'b1;
            end
            if (fin_fire) begin
                mode_reg  <= mode_next;
                level_reg <= level_next;
                irq_reg   <= irq_next;
                fifo_reg  <= fifo_next;
                fill_reg  <= fill_next;
                head_reg  <= head_next;
                if (clear_win) begin
                    count_reg <= '0;
                end
            end
            if (fin_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // window sums cleared with the window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < gpd_pkg::AXES; a++) begin
                sum_reg[a] <= '0;
            end
        end else if (acc_fire) begin
            for (int a = 0; a < gpd_pkg::AXES; a++) begin
                sum_reg[a] <= sum_reg[a] + gpd_pkg::SUM_W'(gyro_in[a]);
            end
        end else if (fin_fire && clear_win) begin
            for (int a = 0; a < gpd_pkg::AXES; a++) begin
                sum_reg[a] <= '0;
            end
        end
    end

    // working registers of one evaluate transfer
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            asleep_reg <= s_tdata[0];
            ready_reg  <= s_tdata[1];
        end
        case (state_reg)
            gpd_pkg::ST_EVAL: begin
                axis_reg   <= '0;
                twitch_reg <= 1'b0;
            end
            gpd_pkg::ST_DSTART: begin
                neg_reg <= scaled[gpd_pkg::DIV_W-1];
            end
            gpd_pkg::ST_DWAIT: begin
                if (div_done) begin
                    mean_reg[axis_reg] <= mean_val;
                    if (axis_reg != LAST_AXIS) begin
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
            end
            gpd_pkg::ST_POST: begin
                axis_reg <= '0;
                ent_reg  <= '0;
                lo_reg   <= mean_reg[0];
                hi_reg   <= mean_reg[0];
            end
            gpd_pkg::ST_SCAN: begin
                if (scan_step) begin
                    if (hist_val < lo_reg) begin
                        lo_reg <= hist_val;
                    end
                    if (hist_val > hi_reg) begin
                        hi_reg <= hist_val;
                    end
                    if (ent_reg != LAST_ENT) begin
                        ent_reg <= ent_reg + 1'b1;
                    end
                end
            end
            gpd_pkg::ST_SPREAD: begin
                if (over) begin
                    twitch_reg <= 1'b1;
                end else if (axis_reg != LAST_AXIS) begin
                    axis_reg <= axis_reg + 1'b1;
                    ent_reg  <= '0;
                    lo_reg   <= mean_reg[axis_reg + 1'b1];
                    hi_reg   <= mean_reg[axis_reg + 1'b1];
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            m_tdata_reg <= {1'b0, fifo_next, irq_next, mode_next, evt, level_next};
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= gpd_pkg::THRESHOLD_RESET;
            limit_reg <= gpd_pkg::WINDOW_RESET;
        end else if (cfg_wr) begin
            case (gpd_pkg::reg_idx_t'(paddr[2]))
                gpd_pkg::REG_THRESHOLD: thr_reg   <= pwdata[gpd_pkg::THR_W-1:0];
                gpd_pkg::REG_WINDOW:    limit_reg <= pwdata[gpd_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (gpd_pkg::reg_idx_t'(paddr[2]))
            gpd_pkg::REG_THRESHOLD: prdata = gpd_pkg::APB_W'(thr_reg);
            gpd_pkg::REG_WINDOW:    prdata = gpd_pkg::APB_W'(limit_reg);
            default:                prdata = '0;
        endcase
    end

    // checks
    `GPD_ASSERT_NXT(a_eval_blocks, aclk, aresetn, s_tvalid && s_tready && (s_tuser == gpd_pkg::OP_EVAL), !s_tready, "evaluate transfer did not hold off the input")
    `GPD_ASSERT_IMP(a_event_level, aclk, aresetn, m_tvalid && (m_tdata[2:1] == gpd_pkg::EVT_PICKED_UP), m_tdata[0], "pickup event without pickup level")
    `GPD_ASSERT_IMP(a_inactive_fifo, aclk, aresetn, m_tvalid && (m_tdata[4:3] == gpd_pkg::MODE_INACTIVE), !m_tdata[6], "fifo running in inactive mode")
    `GPD_ASSERT_IMP(a_gyro_irq, aclk, aresetn, m_tvalid && (m_tdata[4:3] == gpd_pkg::MODE_GYRO), !m_tdata[5], "interrupts on in gyro only mode")

endmodule

// ===== verif/tb_gyro_pickup_detector.sv =====
module tb_gyro_pickup_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import gpd_pkg::*;

    localparam int HIST_DEPTH    = 3;
    // settle time for a taken window still being worked on at this depth
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD     = 1500;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int THR_MAX       = (1 << THR_W) - 1;
    localparam int LIMIT_MAX     = (1 << LIMIT_W) - 1;

    // one input transfer: op travels on s_tuser, the rest on s_tdata
    typedef struct packed {
        op_t                         op;
        logic                        asleep;
        logic                        ready;
        logic [AXES-1:0][GYRO_W-1:0] rate;
    } gyro_item_t;

    // one result transfer, laid out as the low bits of m_tdata, top bit first
    typedef struct packed {
        logic        fifo;
        logic        irq;
        mode_t       mode;
        pick_event_t evt;
        logic        level;
    } status_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [APB_W-1:0]      pwdata   = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    gyro_pickup_detector #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // transfers waiting to be offered, and statuses still owed by the block
    gyro_item_t pending_items[$];
    status_t    status_due[$];

    // mirror of the detector state
    int    thr_cfg = THRESHOLD_RESET;
    int    lim_cfg = WINDOW_RESET;
    mode_t mode_now = MODE_ACTIVE;
    int    axis_sum[AXES];
    int    sample_count;
    int    mean_hist[HIST_DEPTH][AXES];
    int    hist_fill;
    int    hist_head;
    logic  level_now = 1'b0;
    logic  irq_now   = 1'b1;
    logic  fifo_now  = 1'b1;
    int    fresh_mean[AXES];

    // bookkeeping
    int         mismatches;
    int         queued_items;
    int         accepted_items;
    int         eval_items;
    int         results_seen;
    int         pickups;
    int         put_downs;
    int         settings_used;
    int         cycle_count;
    int         hold_left;
    bit         hold_done;
    bit         calm;
    gyro_item_t offered;
    status_t    got;
    status_t    want;

    // stimulus shaping: a spell of windows is either held still or moving
    int spell_left;
    bit spell_still;
    int jitter;
    int rest_base[AXES];

    initial begin
        for (int a = 0; a < AXES; a++) begin
            axis_sum[a] = 0;
        end
        sample_count = 0;
        hist_fill    = 0;
        hist_head    = 0;
    end

    // ---------------------------------------------------------------
    // detector mirror
    // ---------------------------------------------------------------

    // window mean per axis, raw lsb with four fraction bits, cut toward zero;
    // an empty window gives zero, and taking the mean clears the window
    function automatic void take_window_mean();
        for (int a = 0; a < AXES; a++) begin
            fresh_mean[a] = (sample_count == 0) ? 0 : (axis_sum[a] * 16) / sample_count;
            axis_sum[a] = 0;
        end
        sample_count = 0;
    endfunction

    // spread over the history and the new mean, any axis over the threshold
    function automatic bit spread_exceeded();
        int lo;
        int hi;
        for (int a = 0; a < AXES; a++) begin
            lo = fresh_mean[a];
            hi = fresh_mean[a];
            for (int i = 0; i < hist_fill; i++) begin
                if (mean_hist[i][a] < lo) lo = mean_hist[i][a];
                if (mean_hist[i][a] > hi) hi = mean_hist[i][a];
            end
            if (hi - lo > thr_cfg) return 1'b1;
        end
        return 1'b0;
    endfunction

    // new mean enters the history, oldest entry drops once full
    function automatic void remember_mean();
        int slot;
        if (hist_fill < HIST_DEPTH) begin
            slot = (hist_head + hist_fill) % HIST_DEPTH;
            hist_fill++;
        end else begin
            slot = hist_head;
            hist_head = (hist_head + 1) % HIST_DEPTH;
        end
        for (int a = 0; a < AXES; a++) begin
            mean_hist[slot][a] = fresh_mean[a];
        end
    endfunction

    // one accepted transfer; an evaluate leaves the status it must produce
    function automatic void detector_step(input gyro_item_t it);
        logic    was;
        status_t st;
        was = level_now;
        if (it.op == OP_SAMPLE) begin
            // samples are dropped while the fifo is stopped or the window is full
            if (fifo_now && sample_count < lim_cfg) begin
                for (int a = 0; a < AXES; a++) begin
                    axis_sum[a] += $signed(it.rate[a]);
                end
                sample_count++;
            end
            return;
        end
        case (mode_now)
            MODE_GYRO: begin
                // sleep flag plays no part while the gyro loop decides
                if (it.ready) begin
                    take_window_mean();
                    if (hist_fill >= HIST_DEPTH) begin
                        if (spread_exceeded()) begin
                            level_now = 1'b1;
                        end else begin
                            mode_now = MODE_ACTIVE;
                            irq_now  = 1'b1;
                        end
                    end
                    remember_mean();
                end
            end
            MODE_ACTIVE: begin
                if (it.asleep) begin
                    // put down: stop the loop, sums stay until the next start
                    level_now = 1'b0;
                    mode_now  = MODE_INACTIVE;
                    fifo_now  = 1'b0;
                end else if (it.ready) begin
                    take_window_mean();
                    if (hist_fill >= HIST_DEPTH && spread_exceeded()) begin
                        level_now = 1'b1;
                        mode_now  = MODE_GYRO;
                        irq_now   = 1'b0;
                    end
                    remember_mean();
                end
            end
            default: begin
                // inactive: waking up starts the gyro loop from a clean slate,
                // a ready window is ignored here
                if (!it.asleep) begin
                    mode_now     = MODE_GYRO;
                    irq_now      = 1'b0;
                    fifo_now     = 1'b1;
                    hist_fill    = 0;
                    hist_head    = 0;
                    sample_count = 0;
                    for (int a = 0; a < AXES; a++) begin
                        axis_sum[a] = 0;
                    end
                end
            end
        endcase
        st.level = level_now;
        st.evt   = (was == level_now) ? EVT_NONE : (level_now ? EVT_PICKED_UP : EVT_PUT_DOWN);
        st.mode  = mode_now;
        st.irq   = irq_now;
        st.fifo  = fifo_now;
        if (st.evt == EVT_PICKED_UP) pickups++;
        if (st.evt == EVT_PUT_DOWN) put_downs++;
        eval_items++;
        status_due.push_back(st);
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    function automatic void queue_item(input op_t op, input bit sleepy, input bit rdy,
                                       input logic [GYRO_W-1:0] x, input logic [GYRO_W-1:0] y,
                                       input logic [GYRO_W-1:0] z);
        gyro_item_t it;
        it.op      = op;
        it.asleep  = sleepy;
        it.ready   = rdy;
        it.rate[0] = x;
        it.rate[1] = y;
        it.rate[2] = z;
        pending_items.push_back(it);
        queued_items++;
    endfunction

    // a still spell hovers around a base, a moving one spans the full range
    function automatic logic [GYRO_W-1:0] rate_value(input int a);
        int v;
        if (spell_still) begin
            v = rest_base[a] + int'($urandom_range(2 * jitter)) - jitter;
            return GYRO_W'(v);
        end
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return GYRO_W'($urandom);
    endfunction

    // the unused flags of a sample carry random bits
    function automatic void queue_sample();
        queue_item(OP_SAMPLE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   rate_value(0), rate_value(1), rate_value(2));
    endfunction

    // the gyro fields of an evaluate carry random bits
    function automatic void queue_eval(input bit sleepy, input bit rdy);
        queue_item(OP_EVAL, sleepy, rdy, GYRO_W'($urandom), GYRO_W'($urandom),
                   GYRO_W'($urandom));
    endfunction

    // mostly a window of samples closed by an evaluate, now and then noise
    function automatic void queue_episode();
        int n;
        int roll;
        if (spell_left == 0) begin
            spell_left  = $urandom_range(10, 3);
            spell_still = ($urandom_range(99) < 60);
            jitter      = $urandom_range(4);
            for (int a = 0; a < AXES; a++) begin
                rest_base[a] = ($urandom_range(99) < 30) ? 0 : int'($urandom_range(4000)) - 2000;
            end
        end
        spell_left--;
        roll = $urandom_range(99);
        if (roll < 8) begin
            if (roll < 4) queue_sample();
            else queue_eval(1'($urandom_range(1)), 1'($urandom_range(1)));
            return;
        end
        // a few windows overrun the limit, most stay small
        if ($urandom_range(19) == 0) n = lim_cfg + $urandom_range(3);
        else n = $urandom_range(((lim_cfg < 16) ? lim_cfg : 16) + 1);
        repeat (n) queue_sample();
        if (roll < 20) queue_eval(1'b0, 1'b0);
        queue_eval($urandom_range(99) < 7, $urandom_range(99) < 88);
    endfunction

    function automatic void queue_random(input int count);
        int stop;
        stop = queued_items + count;
        while (queued_items < stop) queue_episode();
    endfunction

    // ---------------------------------------------------------------
    // configuration and checking helpers
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input int wanted, input int actual);
        if (wanted != actual) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, wanted, actual);
            mismatches++;
        end
    endtask

    // setup cycle, then access until pready
    task automatic apb_transfer(input bit write, input reg_idx_t idx,
                                input logic [APB_W-1:0] wdata, output logic [APB_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write both registers, update the mirror, read both back
    task automatic set_config(input int thr, input int lim);
        logic [APB_W-1:0] rd;
        apb_transfer(1'b1, REG_THRESHOLD, APB_W'(thr), rd);
        apb_transfer(1'b1, REG_WINDOW, APB_W'(lim), rd);
        thr_cfg = thr & THR_MAX;
        lim_cfg = lim & LIMIT_MAX;
        apb_transfer(1'b0, REG_THRESHOLD, '0, rd);
        check_field("twitch_threshold readback", thr_cfg, int'(rd));
        apb_transfer(1'b0, REG_WINDOW, '0, rd);
        check_field("window_limit readback", lim_cfg, int'(rd));
        settings_used++;
    endtask

    // everything offered and every status back
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || status_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // drained, then room for a window still being worked on after a sample
    task automatic finish_phase();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------
    // input driver: holds a transfer until taken, idles at random
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                detector_step(offered);
                accepted_items++;
            end
            if (s_tvalid && !s_tready) begin
                // stalled: keep the same transfer on the bus
            end else if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
                offered  = pending_items.pop_front();
                s_tuser  <= offered.op;
                s_tdata  <= IN_DATA_W'({offered.rate, offered.ready, offered.asleep});
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor: checks each status, stalls at random, and once
    // holds off long enough that the block backs up into its input
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = status_t'(m_tdata[$bits(status_t)-1:0]);
                if (status_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = status_due.pop_front();
                    check_field("picked_up", want.level, got.level);
                    check_field("pick_event", want.evt, got.evt);
                    check_field("mode", want.mode, got.mode);
                    check_field("sleep_detect_on", want.irq, got.irq);
                    check_field("fifo_running", want.fifo, got.fifo);
                end
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && results_seen >= 30) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 35);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d statuses outstanding",
                     cycle_count, status_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence of phases
    // ---------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings; starts in active mode
        queue_eval(1'b0, 1'b0);                          // active, nothing to do
        queue_eval(1'b0, 1'b1);                          // empty window, zero mean
        queue_item(OP_SAMPLE, 1'b0, 1'b0, 16'h7FFF, 16'h8000, 16'h0000);
        queue_item(OP_SAMPLE, 1'b1, 1'b1, 16'h8000, 16'h7FFF, 16'hFFFF);
        queue_eval(1'b0, 1'b1);                          // negative mean
        queue_eval(1'b0, 1'b1);                          // history now full
        queue_item(OP_SAMPLE, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_eval(1'b0, 1'b1);                          // big spread, picked up
        queue_eval(1'b1, 1'b0);                          // sleep ignored in gyro mode
        queue_eval(1'b0, 1'b1);
        queue_eval(1'b1, 1'b1);
        queue_eval(1'b0, 1'b1);
        queue_eval(1'b0, 1'b1);                          // flat history, back to active
        queue_eval(1'b1, 1'b0);                          // asleep, put down, fifo off
        queue_item(OP_SAMPLE, 1'b0, 1'b0, 16'h1234, 16'hEDCB, 16'h0001);  // fifo stopped
        queue_eval(1'b1, 1'b1);                          // inactive ignores the window
        queue_eval(1'b0, 1'b0);                          // wake up, loop restarts
        queue_eval(1'b0, 1'b1);                          // dropped sample left no trace
        queue_random(200);
        finish_phase();

        // tightest threshold, one sample per window
        set_config(0, 1);
        queue_eval(1'b0, 1'b0);
        queue_sample();
        queue_sample();                                  // beyond the window limit
        queue_eval(1'b0, 1'b1);
        queue_random(200);
        finish_phase();

        // widest settings, both sides without idling
        set_config(THR_MAX, LIMIT_MAX);
        calm = 1'b1;
        queue_random(200);
        finish_phase();
        calm = 1'b0;

        // middle settings, with the sender pausing until all statuses are back
        set_config($urandom_range(600, 16), $urandom_range(20, 2));
        queue_random(100);
        wait_drained();
        queue_random(100);
        finish_phase();

        // window limit zero: nothing accumulates, so every fresh window has a zero mean
        set_config(THRESHOLD_RESET, 0);
        queue_eval(1'b0, 1'b0);
        queue_sample();
        queue_eval(1'b0, 1'b1);
        queue_random(120);
        finish_phase();

        // reset values written back explicitly
        set_config(THRESHOLD_RESET, WINDOW_RESET);
        queue_random(200);
        finish_phase();

        $display("covered %0d input transfers (%0d evaluates) and %0d results checked",
                 accepted_items, eval_items, results_seen);
        $display("%0d pickups, %0d put-downs over %0d register settings, %0d mismatches",
                 pickups, put_downs, settings_used, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== gyro_pickup_detector.f =====
+incdir+sv
sv/gpd_pkg.sv
sv/gpd_divider.sv
sv/gpd_history.sv
sv/gyro_pickup_detector.sv
verif/tb_gyro_pickup_detector.sv
